// ===== sv/rthp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rthp_pkg: shared types and helpers for the RGB to HSV pixel core
// Carries the divider lane format, the hue sector code and the step function
// of the restoring divider used for saturation and hue.
// ----------------------------------------------------------------------------
package rthp_pkg;

	localparam int DIV_STEPS_PER_STAGE = 2;
	localparam int DIV_STAGES          = 4;

	localparam logic [7:0] OFS_GREEN = 8'd60;
	localparam logic [7:0] OFS_BLUE  = 8'd120;
	localparam logic [7:0] OFS_RED_N = 8'd180;

	typedef enum logic [1:0] {
		SECT_RED_POS,
		SECT_RED_NEG,
		SECT_GREEN,
		SECT_BLUE
	} hue_sect_t;

	typedef struct packed {
		logic [7:0] rem;
		logic [7:0] low;
		logic [7:0] quo;
		logic [7:0] dvs;
	} div_lane_t;

	typedef struct packed {
		div_lane_t  sat;
		div_lane_t  hue;
		logic [7:0] brightness;
	} div_item_t;

	function automatic div_lane_t div_step(input div_lane_t a);
		logic [8:0] t;
		div_lane_t  r;
		r = a;
		t = {a.rem, a.low[7]};
		if (t >= {1'b0, a.dvs}) begin
			r.rem = 8'(t - {1'b0, a.dvs});
			r.quo = {a.quo[6:0], 1'b1};
		end else begin
			r.rem = t[7:0];
			r.quo = {a.quo[6:0], 1'b0};
		end
		r.low = {a.low[6:0], 1'b0};
		return r;
	endfunction

	function automatic logic [15:0] sect_offset(input hue_sect_t s, input logic [7:0] d);
		logic [15:0] r;
		case (s)
			SECT_RED_POS: r = 16'd0;
			SECT_RED_NEG: r = 16'(d) * 16'(OFS_RED_N);
			SECT_GREEN:   r = 16'(d) * 16'(OFS_GREEN);
			SECT_BLUE:    r = 16'(d) * 16'(OFS_BLUE);
			default:      r = 16'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== sv/rgb_to_hsv_pixel_core.sv =====
`default_nettype none
// A pixel goes through both front-end registers and then each divider stage.
// Throughput: one pixel per clock; the 4-stage divider (2 quotient bits per stage)
// and the 2-stage front end each take a new item every cycle unless stalled.
// Stall ripples back only through stages that hold an item, so bubbles fill up.
// Reset clears the valid bits of all 6 stages; no result is shown after reset.
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel_core: 8-bit BGR pixel to HSV, hue in half degrees
// Front end forms max, spread and dividends; a restoring divider pipeline
// yields saturation and hue.
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel_core
	import rthp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] blue,
	input  wire logic [7:0] green,
	input  wire logic [7:0] red,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      hue,
	output logic [7:0]      saturation,
	output logic [7:0]      brightness
);

	logic      valid_c [DIV_STAGES+1];
	logic      stall_c [DIV_STAGES+1];
	div_item_t item_c  [DIV_STAGES+1];

	rthp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (in_valid),
		.up_stall (in_stall),
		.blue     (blue),
		.green    (green),
		.red      (red),
		.dn_valid (valid_c[0]),
		.dn_stall (stall_c[0]),
		.dn_item  (item_c[0])
	);

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		rthp_div_stage u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (valid_c[k]),
			.up_stall (stall_c[k]),
			.up_item  (item_c[k]),
			.dn_valid (valid_c[k+1]),
			.dn_stall (stall_c[k+1]),
			.dn_item  (item_c[k+1])
		);
	end

	assign stall_c[DIV_STAGES] = out_stall;
	assign out_valid           = valid_c[DIV_STAGES];
	assign hue                 = item_c[DIV_STAGES].hue.quo;
	assign saturation          = item_c[DIV_STAGES].sat.quo;
	assign brightness          = item_c[DIV_STAGES].brightness;

`ifndef SYNTHESIS
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> hue <= 8'd179)
		else $error("hue out of range");

	a_black_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && brightness == 8'd0) |-> saturation == 8'd0)
		else $error("black pixel with nonzero saturation");

	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_stall && out_valid)
		else $error("input stalled without an output stall");

	a_gray_hue: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && saturation == 8'd0) |-> hue == 8'd0)
		else $error("gray pixel with nonzero hue");
`endif

endmodule
`default_nettype wire

// ===== sv/rthp_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rthp_front: channel compare and dividend forming
// First stage finds max, spread and hue sector; second stage builds the
// saturation and hue dividends and divisors for the divider pipeline.
// ----------------------------------------------------------------------------
module rthp_front
	import rthp_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      up_valid,
	output logic           up_stall,
	input  wire logic [7:0] blue,
	input  wire logic [7:0] green,
	input  wire logic [7:0] red,
	output logic           dn_valid,
	input  wire logic      dn_stall,
	output div_item_t      dn_item
);

	logic              valid_s1;
	logic [7:0]        mx_s1;
	logic [7:0]        diff_s1;
	logic signed [8:0] num_s1;
	hue_sect_t         sect_s1;
	logic              valid_s2;
	div_item_t         item_s2;

	logic              stall_s1;
	logic              stall_s2;

	logic [7:0]        mx_c;
	logic [7:0]        mn_c;
	logic signed [8:0] num_c;
	hue_sect_t         sect_c;

	logic [15:0]        sat_dvd;
	logic signed [16:0] hue_tot;
	logic [15:0]        hue_dvd;
	div_item_t          item_c;

	assign stall_s2 = valid_s2 & dn_stall;
	assign stall_s1 = valid_s1 & stall_s2;
	assign up_stall = stall_s1;

	always_comb begin
		if (red >= green && red >= blue) begin
			mx_c   = red;
			num_c  = signed'({1'b0, green}) - signed'({1'b0, blue});
			sect_c = (green < blue) ? SECT_RED_NEG : SECT_RED_POS;
		end else if (green >= blue) begin
			mx_c   = green;
			num_c  = signed'({1'b0, blue}) - signed'({1'b0, red});
			sect_c = SECT_GREEN;
		end else begin
			mx_c   = blue;
			num_c  = signed'({1'b0, red}) - signed'({1'b0, green});
			sect_c = SECT_BLUE;
		end
		mn_c = (red < green) ? red : green;
		mn_c = (blue < mn_c) ? blue : mn_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!stall_s1) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall_s1 && up_valid) begin
			mx_s1   <= mx_c;
			diff_s1 <= mx_c - mn_c;
			num_s1  <= num_c;
			sect_s1 <= sect_c;
		end
	end

	always_comb begin
		sat_dvd = {diff_s1, 8'd0} - {8'd0, diff_s1};
		hue_tot = (17'(num_s1) <<< 5) - (17'(num_s1) <<< 1)
		        + signed'({1'b0, sect_offset(sect_s1, diff_s1)});
		hue_dvd = hue_tot[16] ? 16'd0 : hue_tot[15:0];

		item_c.sat.rem    = sat_dvd[15:8];
		item_c.sat.low    = sat_dvd[7:0];
		item_c.sat.quo    = 8'd0;
		item_c.sat.dvs    = (mx_s1 == 8'd0) ? 8'd1 : mx_s1;
		item_c.hue.rem    = hue_dvd[15:8];
		item_c.hue.low    = hue_dvd[7:0];
		item_c.hue.quo    = 8'd0;
		item_c.hue.dvs    = (diff_s1 == 8'd0) ? 8'd1 : diff_s1;
		item_c.brightness = mx_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!stall_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall_s2 && valid_s1) begin
			item_s2 <= item_c;
		end
	end

	assign dn_valid = valid_s2;
	assign dn_item  = item_s2;

endmodule
`default_nettype wire

// ===== sv/rthp_div_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rthp_div_stage: one stage of the restoring divider pipeline
// Advances the saturation and hue quotients by two bits each.
// ----------------------------------------------------------------------------
module rthp_div_stage
	import rthp_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      up_valid,
	output logic           up_stall,
	input  wire div_item_t up_item,
	output logic           dn_valid,
	input  wire logic      dn_stall,
	output div_item_t      dn_item
);

	logic      valid_q;
	div_item_t item_q;
	div_item_t item_c;

	assign up_stall = valid_q & dn_stall;

	always_comb begin
		item_c = up_item;
		for (int i = 0; i < DIV_STEPS_PER_STAGE; i++) begin
			item_c.sat = div_step(item_c.sat);
			item_c.hue = div_step(item_c.hue);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!up_stall) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!up_stall && up_valid) begin
			item_q <= item_c;
		end
	end

	assign dn_valid = valid_q;
	assign dn_item  = item_q;

endmodule
`default_nettype wire
